@@ hw/rtl/int_to_base_ascii_top_assert.svh @@
// Assertion macros shared by the RTL of the integer to ASCII converter.
`ifndef INT_TO_BASE_ASCII_TOP_ASSERT_SVH
`define INT_TO_BASE_ASCII_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITBA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/itba_pkg.sv @@
package itba_pkg;

    localparam int RADIX_W = 6;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 7'h5A;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    localparam logic [RADIX_W-1:0] DIGIT_MAX = 6'd9;
    localparam logic [CHAR_W-1:0]  DIGIT_TEN = 7'd10;

    // Quotient bits resolved per divider cycle.
    localparam int DIV_STEP = 4;

    typedef struct packed {
        logic load;
        logic div_step;
        logic rd_issue;
        logic out_sign;
        logic out_digit;
    } itba_cmd_t;

    typedef struct packed {
        logic neg;
        logic div_last;
        logic quot_zero;
        logic stack_empty;
    } itba_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {1'b0, d};
        if (d <= DIGIT_MAX) begin
            return CHAR_ZERO + dw;
        end
        return CHAR_A + (dw - DIGIT_TEN);
    endfunction

endpackage

@@ hw/rtl/itba_ctrl.sv @@
module itba_ctrl
    import itba_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  itba_status_t status,
    output itba_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_SIGN,
        S_READ,
        S_SHOW
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    // The output register may be loaded when empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!status.quot_zero) begin
                    state_next = S_DIV;
                end else if (status.neg) begin
                    state_next = S_SIGN;
                end else begin
                    state_next = S_READ;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    cmd.out_sign = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_SHOW;
            end
            S_SHOW: begin
                if (out_free) begin
                    cmd.out_digit = 1'b1;
                    state_next    = status.stack_empty ? S_IDLE : S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_sign || cmd.out_digit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

@@ hw/rtl/itba_dp.sv @@
module itba_dp
    import itba_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [RADIX_W-1:0]     cfg_data,
    input  logic [VALUE_WIDTH-1:0] in_value,
    input  itba_cmd_t              cmd,
    output itba_status_t           status,
    output logic [CHAR_W-1:0]      out_char,
    output logic                   out_last
);

    localparam int DIV_W = ((VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int ITERS = DIV_W / DIV_STEP;
    localparam int IW    = $clog2(ITERS);
    localparam int CW    = $clog2(VALUE_WIDTH + 1);
    localparam int AW    = $clog2(VALUE_WIDTH);

    logic [RADIX_W-1:0]     radix_reg;
    logic [DIV_W-1:0]       mag_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [IW-1:0]          iter_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   neg_reg;
    logic [RADIX_W-1:0]     rd_data_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;
    logic [RADIX_W-1:0]     digit_mem [VALUE_WIDTH];

    logic [VALUE_WIDTH-1:0] mag_abs;
    logic [DIV_W-1:0]       step_mag;
    logic [RADIX_W-1:0]     step_rem;
    logic                   iter_last;
    logic [CW-1:0]          cnt_dec;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;

    assign mag_abs   = in_value[VALUE_WIDTH-1] ? (~in_value + VALUE_WIDTH'(1)) : in_value;
    assign iter_last = (iter_reg == IW'(ITERS - 1));
    assign cnt_dec   = cnt_reg - CW'(1);
    assign wr_addr   = cnt_reg[AW-1:0];
    assign rd_addr   = cnt_dec[AW-1:0];

    // Restoring division, several quotient bits per cycle. Dividend bits
    // leave the top of mag_reg while quotient bits enter at the bottom.
    always_comb begin
        logic [RADIX_W:0] wide;
        step_rem = rem_reg;
        step_mag = mag_reg;
        for (int i = 0; i < DIV_STEP; i++) begin
            wide     = {step_rem, step_mag[DIV_W-1]};
            step_mag = {step_mag[DIV_W-2:0], 1'b0};
            if (wide >= {1'b0, radix_reg}) begin
                wide        = wide - {1'b0, radix_reg};
                step_mag[0] = 1'b1;
            end
            step_rem = wide[RADIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
            iter_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_data < RADIX_MIN) begin
                    radix_reg <= RADIX_MIN;
                end else if (cfg_data > RADIX_MAX) begin
                    radix_reg <= RADIX_MAX;
                end else begin
                    radix_reg <= cfg_data;
                end
            end
            if (cmd.load) begin
                iter_reg <= '0;
                cnt_reg  <= '0;
            end else if (cmd.div_step) begin
                iter_reg <= iter_last ? '0 : iter_reg + IW'(1);
                if (iter_last) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end else if (cmd.rd_issue) begin
                cnt_reg <= cnt_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg <= DIV_W'(mag_abs);
            rem_reg <= '0;
            neg_reg <= in_value[VALUE_WIDTH-1];
        end else if (cmd.div_step) begin
            mag_reg <= step_mag;
            rem_reg <= iter_last ? '0 : step_rem;
        end
        if (cmd.out_sign) begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end else if (cmd.out_digit) begin
            char_reg <= digit_char(rd_data_reg);
            last_reg <= (cnt_reg == '0);
        end
    end

    // Digit stack: written least significant digit first, read back in reverse.
    always_ff @(posedge aclk) begin
        if (cmd.div_step && iter_last) begin
            digit_mem[wr_addr] <= step_rem;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= digit_mem[rd_addr];
        end
    end

    assign status.neg         = neg_reg;
    assign status.div_last    = iter_last;
    assign status.quot_zero   = (mag_reg == '0);
    assign status.stack_empty = (cnt_reg == '0);

    assign out_char = char_reg;
    assign out_last = last_reg;

endmodule

@@ hw/rtl/int_to_base_ascii_top.sv @@
// The block converts one value at a time. The shared divider resolves four quotient bits
// a cycle and pushes each digit, least significant first, onto the digit stack; the
// controller then reads the stack back into the output register, most significant digit
// first. For a negative value the sign leads, ahead of the first digit.
// Reset (aresetn low at a clock edge, synchronous) empties the block and sets the radix to 10.
// The next input is taken while the last character still waits in the output register.

`include "int_to_base_ascii_top_assert.svh"

module int_to_base_ascii_top
    import itba_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Radix register write channel; always ready.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [RADIX_W-1:0]                  cfg_data,   // radix, saturated to 2..36

    // Input stream of signed integers.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,    // value (signed), zero fill above

    // Output stream of ASCII characters, one character per transfer.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,    // character [6:0], zero bit [7]
    output logic                                m_tlast     // final character of the string
);

    itba_cmd_t         cmd;
    itba_status_t      status;
    logic [CHAR_W-1:0] out_char;

    // Helper terms for the checks at the end of the module.
    logic              in_xfer;
    logic              out_is_sign;
    logic              out_is_legal;

    // The radix register accepts a transfer in every cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences loading, division per digit, the optional
    // sign and the readback of the digit stack into the output register.
    itba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the radix, the magnitude divider, the digit
    // stack and the output payload register.
    itba_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_value  (s_tdata[VALUE_WIDTH-1:0]),
        .cmd       (cmd),
        .status    (status),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

    assign in_xfer      = s_tvalid && s_tready;
    assign out_is_sign  = m_tvalid && (out_char == CHAR_MINUS);
    assign out_is_legal = ((out_char >= CHAR_ZERO) && (out_char <= CHAR_NINE)) ||
                          ((out_char >= CHAR_A) && (out_char <= CHAR_Z)) ||
                          (out_char == CHAR_MINUS);

    // The sign is never the final character of a string.
    `ITBA_ASSERT_SAME(a_sign_not_last, out_is_sign, !m_tlast, "sign marked last")

    // Every character shown is a digit, a capital letter or the sign.
    `ITBA_ASSERT_SAME(a_char_legal, m_tvalid, out_is_legal, "illegal character")

    // A new value starts with division, so no character appears right after its transfer.
    `ITBA_ASSERT_NEXT(a_no_early_out, in_xfer, !$rose(m_tvalid) && !s_tready, "output too early")

endmodule
